/* design/clock_offset_pi_pll_core_assert.svh */
// Assertion macros for the clock offset PI loop core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CLOCK_OFFSET_PI_PLL_CORE_ASSERT_SVH
`define CLOCK_OFFSET_PI_PLL_CORE_ASSERT_SVH

// condition must hold at every edge out of reset
`define COPLL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define COPLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/copll_pkg.sv */
// Shared types and codes for the clock offset PI loop core.
// No dependencies.
`timescale 1ns / 1ps

package copll_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PMUL,
        ST_PDIV,
        ST_IMUL,
        ST_IDIV,
        ST_INTEG,
        ST_TARGET,
        ST_DIFF,
        ST_EMUL,
        ST_FREQ,
        ST_PHDIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        STAT_ACCEPT = 2'd0,
        STAT_SEED   = 2'd1,
        STAT_REJECT = 2'd2
    } status_t;

    localparam logic [7:0] REG_PROP_GAIN   = 8'd0;
    localparam logic [7:0] REG_INTEG_GAIN  = 8'd1;
    localparam logic [7:0] REG_SMOOTH      = 8'd2;
    localparam logic [7:0] REG_LOCK_THRESH = 8'd3;

    localparam int MUL_STEPS = 19;

endpackage

/* design/clock_offset_pi_pll_core.sv */
// Throughput: one sample at a time; a seeded or rejected sample goes from the check
// straight to the output, while for an accepted one three bit-serial divides on one
// shared divider and three 19-step shift-add multiplies on one shared multiplier
// set the sample time.
// Reset: asynchronous, active low; loop state and gains return to defaults.
// Depends on copll_pkg and clock_offset_pi_pll_core_assert.svh.
`timescale 1ns / 1ps

module clock_offset_pi_pll_core #(
    parameter int FRAC_BITS  = 40,
    parameter int LOCK_COUNT = 10
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  logic [95:0]                                 s_axis_tdata,  // offset_us, stamp_us
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // freq_adjust, phase_adjust, last_error
    output logic [((FRAC_BITS+66+7)/8)*8-1:0]           m_axis_tdata,
    output logic [2:0]                                  m_axis_tuser,  // locked, sample_status
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [7:0]                                  cfg_index,
    input  logic [23:0]                                 cfg_data
);

    localparam int F    = FRAC_BITS;
    localparam int SW   = F + 14;
    localparam int AW   = F + 2;
    localparam int BW   = copll_pkg::MUL_STEPS;
    localparam int PW   = AW + BW;
    localparam int DW   = F + 35;
    localparam int RW   = 25;
    localparam int CW   = $clog2(DW + 1);
    localparam int IW   = F - 2;
    localparam int FW   = F + 1;
    localparam int OUTW = ((F + 66 + 7) / 8) * 8;

    localparam logic [63:0] ONE_U  = 64'd1 << F;
    localparam logic [63:0] ILIM_U = (ONE_U + 64'd5) / 64'd10;
    localparam logic [63:0] FLO_U  = (64'd9 * ONE_U + 64'd5) / 64'd10;
    localparam logic [63:0] FHI_U  = (64'd11 * ONE_U + 64'd5) / 64'd10;

    localparam logic signed [SW-1:0] ONE_S  = SW'(ONE_U);
    localparam logic signed [SW-1:0] ILIM_S = SW'(ILIM_U);
    localparam logic signed [SW-1:0] FLO_S  = SW'(FLO_U);
    localparam logic signed [SW-1:0] FHI_S  = SW'(FHI_U);
    localparam logic [FW-1:0]        ONE_F  = FW'(ONE_U);
    localparam logic [FW-1:0]        FLO_F  = FW'(FLO_U);
    localparam logic [FW-1:0]        FHI_F  = FW'(FHI_U);
    localparam logic [3:0]           LOCK_N = 4'(LOCK_COUNT);

    copll_pkg::state_t  state_reg, state_next;

    logic [18:0]        prop_gain_reg, prop_gain_next;
    logic [16:0]        integ_gain_reg, integ_gain_next;
    logic [15:0]        smooth_reg, smooth_next;
    logic [23:0]        thresh_reg, thresh_next;

    logic [62:0]        last_time_reg, last_time_next;
    logic [31:0]        last_off_reg, last_off_next;
    logic [IW-1:0]      integ_reg, integ_next;
    logic [FW-1:0]      freq_reg, freq_next;
    logic [32:0]        phase_reg, phase_next;
    logic [3:0]         stable_reg, stable_next;
    logic               lock_reg, lock_next;
    logic [1:0]         status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    logic [CW-1:0]      cnt_reg, cnt_next;

    logic [31:0]        off_reg, off_next;
    logic [62:0]        stamp_reg, stamp_next;
    logic [AW-1:0]      mul_a_reg, mul_a_next;
    logic [BW-1:0]      mul_b_reg, mul_b_next;
    logic [PW-1:0]      acc_reg, acc_next;
    logic [DW-1:0]      div_reg, div_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic               div_ten_reg, div_ten_next;
    logic               neg_reg, neg_next;
    logic signed [SW-1:0] p_reg, p_next;
    logic signed [SW-1:0] i_reg, i_next;
    logic [FW-1:0]      tgt_reg, tgt_next;
    logic [FW-1:0]      fout_reg, fout_next;
    logic [32:0]        pout_reg, pout_next;
    logic               lout_reg, lout_next;
    logic [31:0]        eout_reg, eout_next;
    logic [1:0]         sout_reg, sout_next;

    logic               in_fire;
    logic               mul_done;
    logic               div_done;
    logic               out_free;

    logic               off_neg;
    logic [31:0]        off_mag;
    logic signed [63:0] delta;
    logic               delta_bad;
    logic [RW:0]        div_t;
    logic [RW:0]        divisor;
    logic               div_ge;
    logic signed [SW-1:0] quot_s;
    logic signed [SW-1:0] term_s;
    logic signed [SW-1:0] isum;
    logic signed [SW-1:0] tsum;
    logic signed [F+1:0]  diff;
    logic [PW-17:0]     corr;
    logic signed [37:0] ph_num;
    logic [37:0]        ph_mag;
    logic signed [33:0] ph_q;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign mul_done = (cnt_reg == CW'(BW));
    assign div_done = (cnt_reg == CW'(DW));
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            copll_pkg::ST_IDLE:
                if (s_axis_tvalid) state_next = copll_pkg::ST_CHECK;
            copll_pkg::ST_CHECK:
                if (last_time_reg == 63'd0 || delta_bad) state_next = copll_pkg::ST_DONE;
                else state_next = copll_pkg::ST_PMUL;
            copll_pkg::ST_PMUL:  if (mul_done) state_next = copll_pkg::ST_PDIV;
            copll_pkg::ST_PDIV:  if (div_done) state_next = copll_pkg::ST_IMUL;
            copll_pkg::ST_IMUL:  if (mul_done) state_next = copll_pkg::ST_IDIV;
            copll_pkg::ST_IDIV:  if (div_done) state_next = copll_pkg::ST_INTEG;
            copll_pkg::ST_INTEG:  state_next = copll_pkg::ST_TARGET;
            copll_pkg::ST_TARGET: state_next = copll_pkg::ST_DIFF;
            copll_pkg::ST_DIFF:   state_next = copll_pkg::ST_EMUL;
            copll_pkg::ST_EMUL:  if (mul_done) state_next = copll_pkg::ST_FREQ;
            copll_pkg::ST_FREQ:   state_next = copll_pkg::ST_PHDIV;
            copll_pkg::ST_PHDIV: if (div_done) state_next = copll_pkg::ST_DONE;
            copll_pkg::ST_DONE:  if (out_free) state_next = copll_pkg::ST_IDLE;
            default:              state_next = copll_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == copll_pkg::ST_IDLE);
        cfg_ready     = 1'b1;
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = OUTW'({eout_reg, pout_reg, fout_reg});
        m_axis_tuser  = {sout_reg, lout_reg};
    end

    always_comb
    begin
        off_neg   = off_reg[31];
        off_mag   = off_neg ? 32'(33'd0 - {1'b0, off_reg}) : off_reg;
        delta     = $signed({1'b0, stamp_reg}) - $signed({1'b0, last_time_reg});
        delta_bad = (delta <= 64'sd1000) || (delta > 64'sd5000000);
        divisor   = div_ten_reg ? (RW+1)'(10) : (RW+1)'(10000000);
        div_t     = {rem_reg, div_reg[DW-1]};
        div_ge    = (div_t >= divisor);
        quot_s    = $signed(div_reg[SW-1:0]);
        term_s    = neg_reg ? -quot_s : quot_s;
        isum      = SW'($signed(integ_reg)) + i_reg;
        tsum      = ONE_S - (p_reg + SW'($signed(integ_reg)));
        diff      = $signed({1'b0, tgt_reg}) - $signed({1'b0, freq_reg});
        corr      = acc_reg[PW-1:16];
        ph_num    = ($signed({{5{phase_reg[32]}}, phase_reg}) <<< 3)
                    + $signed({{5{phase_reg[32]}}, phase_reg})
                    - $signed({{6{off_reg[31]}}, off_reg});
        ph_mag    = ph_num[37] ? 38'(39'd0 - {1'b0, ph_num}) : ph_num;
        ph_q      = $signed(div_reg[33:0]);
    end

    always_comb
    begin
        prop_gain_next  = prop_gain_reg;
        integ_gain_next = integ_gain_reg;
        smooth_next     = smooth_reg;
        thresh_next     = thresh_reg;
        last_time_next  = last_time_reg;
        last_off_next   = last_off_reg;
        integ_next      = integ_reg;
        freq_next       = freq_reg;
        phase_next      = phase_reg;
        stable_next     = stable_reg;
        lock_next       = lock_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        cnt_next        = cnt_reg;
        off_next        = off_reg;
        stamp_next      = stamp_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        acc_next        = acc_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        div_ten_next    = div_ten_reg;
        neg_next        = neg_reg;
        p_next          = p_reg;
        i_next          = i_reg;
        tgt_next        = tgt_reg;
        fout_next       = fout_reg;
        pout_next       = pout_reg;
        lout_next       = lout_reg;
        eout_next       = eout_reg;
        sout_next       = sout_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                copll_pkg::REG_PROP_GAIN:
                    prop_gain_next = (cfg_data[18:0] < 19'd66) ? 19'd66 :
                                     (cfg_data[18:0] > 19'd327680) ? 19'd327680 :
                                     cfg_data[18:0];
                copll_pkg::REG_INTEG_GAIN:
                    integ_gain_next = (cfg_data[16:0] < 17'd7) ? 17'd7 :
                                      (cfg_data[16:0] > 17'd65536) ? 17'd65536 :
                                      cfg_data[16:0];
                copll_pkg::REG_SMOOTH:
                    smooth_next = (cfg_data[15:0] < 16'd66) ? 16'd66 :
                                  (cfg_data[15:0] > 16'd65470) ? 16'd65470 :
                                  cfg_data[15:0];
                copll_pkg::REG_LOCK_THRESH:
                    thresh_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            copll_pkg::ST_IDLE:
                if (in_fire)
                begin
                    off_next   = s_axis_tdata[31:0];
                    stamp_next = s_axis_tdata[94:32];
                end
            copll_pkg::ST_CHECK:
            begin
                cnt_next   = '0;
                acc_next   = '0;
                mul_a_next = AW'(off_mag);
                mul_b_next = prop_gain_reg;
                neg_next   = off_neg;
                if (last_time_reg == 63'd0)
                begin
                    last_time_next = stamp_reg;
                    last_off_next  = off_reg;
                    phase_next     = 33'(33'd0 - {off_reg[31], off_reg});
                    status_next    = copll_pkg::STAT_SEED;
                end
                else if (delta_bad)
                begin
                    last_time_next = stamp_reg;
                    status_next    = copll_pkg::STAT_REJECT;
                end
            end
            copll_pkg::ST_PMUL, copll_pkg::ST_IMUL, copll_pkg::ST_EMUL:
            begin
                if (!mul_done)
                begin
                    acc_next   = PW'(acc_reg << 1) + (mul_b_reg[BW-1] ? PW'(mul_a_reg) : '0);
                    mul_b_next = mul_b_reg << 1;
                    cnt_next   = cnt_reg + 1'b1;
                end
                else if (state_reg != copll_pkg::ST_EMUL)
                begin
                    div_next     = {acc_reg[50:0], {(F-16){1'b0}}};
                    rem_next     = '0;
                    div_ten_next = 1'b0;
                    cnt_next     = '0;
                end
            end
            copll_pkg::ST_PDIV, copll_pkg::ST_IDIV, copll_pkg::ST_PHDIV:
            begin
                if (!div_done)
                begin
                    rem_next = div_ge ? RW'(div_t - divisor) : RW'(div_t);
                    div_next = {div_reg[DW-2:0], div_ge};
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (state_reg == copll_pkg::ST_PDIV)
                begin
                    p_next     = term_s;
                    cnt_next   = '0;
                    acc_next   = '0;
                    mul_a_next = AW'(off_mag);
                    mul_b_next = BW'(integ_gain_reg);
                end
                else if (state_reg == copll_pkg::ST_IDIV)
                begin
                    i_next = term_s;
                end
                else
                begin
                    phase_next = neg_reg ? 33'(-ph_q) : ph_q[32:0];
                    if (off_mag < {8'd0, thresh_reg})
                    begin
                        if (stable_reg < LOCK_N)
                            stable_next = stable_reg + 4'd1;
                        if (stable_reg + 4'd1 >= LOCK_N)
                            lock_next = 1'b1;
                    end
                    else
                    begin
                        stable_next = 4'd0;
                        lock_next   = 1'b0;
                    end
                    last_off_next  = off_reg;
                    last_time_next = stamp_reg;
                    status_next    = copll_pkg::STAT_ACCEPT;
                end
            end
            copll_pkg::ST_INTEG:
                integ_next = (isum > ILIM_S) ? IW'(ILIM_S) :
                             (isum < -ILIM_S) ? IW'(-ILIM_S) : isum[IW-1:0];
            copll_pkg::ST_TARGET:
                tgt_next = (tsum < FLO_S) ? FLO_F :
                           (tsum > FHI_S) ? FHI_F : tsum[FW-1:0];
            copll_pkg::ST_DIFF:
            begin
                neg_next   = diff[F+1];
                mul_a_next = diff[F+1] ? AW'(-diff) : AW'(diff);
                mul_b_next = BW'(smooth_reg);
                acc_next   = '0;
                cnt_next   = '0;
            end
            copll_pkg::ST_FREQ:
            begin
                freq_next    = neg_reg ? freq_reg - FW'(corr) : freq_reg + FW'(corr);
                neg_next     = ph_num[37];
                div_next     = DW'(ph_mag);
                rem_next     = '0;
                div_ten_next = 1'b1;
                cnt_next     = '0;
            end
            copll_pkg::ST_DONE:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    fout_next      = freq_reg;
                    pout_next      = phase_reg;
                    lout_next      = lock_reg;
                    eout_next      = last_off_reg;
                    sout_next      = status_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= copll_pkg::ST_IDLE;
            prop_gain_reg  <= 19'd32768;
            integ_gain_reg <= 17'd655;
            smooth_reg     <= 16'd32768;
            thresh_reg     <= 24'd1000;
            last_time_reg  <= '0;
            last_off_reg   <= '0;
            integ_reg      <= '0;
            freq_reg       <= ONE_F;
            phase_reg      <= '0;
            stable_reg     <= '0;
            lock_reg       <= 1'b0;
            status_reg     <= copll_pkg::STAT_ACCEPT;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            prop_gain_reg  <= prop_gain_next;
            integ_gain_reg <= integ_gain_next;
            smooth_reg     <= smooth_next;
            thresh_reg     <= thresh_next;
            last_time_reg  <= last_time_next;
            last_off_reg   <= last_off_next;
            integ_reg      <= integ_next;
            freq_reg       <= freq_next;
            phase_reg      <= phase_next;
            stable_reg     <= stable_next;
            lock_reg       <= lock_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg     <= off_next;
        stamp_reg   <= stamp_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        acc_reg     <= acc_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        div_ten_reg <= div_ten_next;
        neg_reg     <= neg_next;
        p_reg       <= p_next;
        i_reg       <= i_next;
        tgt_reg     <= tgt_next;
        fout_reg    <= fout_next;
        pout_reg    <= pout_next;
        lout_reg    <= lout_next;
        eout_reg    <= eout_next;
        sout_reg    <= sout_next;
    end

`include "clock_offset_pi_pll_core_assert.svh"

    `COPLL_ASSERT_ALWAYS(a_freq_range, (freq_reg >= FLO_F) && (freq_reg <= FHI_F), "freq out of range")
    `COPLL_ASSERT_ALWAYS(a_lock_count, !lock_reg || (stable_reg == LOCK_N), "lock without full count")
    `COPLL_ASSERT_NEXT(a_accept_check, in_fire, state_reg == copll_pkg::ST_CHECK, "accept did not start check")

endmodule
